[design/gmpe_pkg.sv]
// ----------------------------------------------------------------------------
// gmpe_pkg - grid monotone path enumerator shared definitions
// grid geometry constants and the sequencer state type
// ----------------------------------------------------------------------------
package gmpe_pkg;

	// grid side length, supported range 2 to 4
	localparam int SIDE   = 4;
	localparam int CELLS  = SIDE * SIDE;
	localparam int NMOVES = 2 * (SIDE - 1);
	localparam int IDX_W  = $clog2(CELLS);
	localparam int POS_W  = $clog2(NMOVES + 1);
	localparam int MASK_W = 16;

	typedef logic [NMOVES-1:0] move_word_t;
	typedef logic [CELLS-1:0]  cell_mask_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic       hit;
		cell_mask_t cells;
	} eval_result_t;

endpackage

[design/gmpe_path_eval.sv]
// ----------------------------------------------------------------------------
// gmpe_path_eval - candidate move word evaluator
// walks one down/right move word over the grid and reports whether it is a
// legal path to the goal, together with the cells it covers
// ----------------------------------------------------------------------------
module gmpe_path_eval (
	input  gmpe_pkg::cell_mask_t   grid_mask,
	input  gmpe_pkg::move_word_t   moves,
	output gmpe_pkg::eval_result_t result
);

	logic [gmpe_pkg::POS_W-1:0] row;
	logic [gmpe_pkg::POS_W-1:0] col;
	logic [gmpe_pkg::POS_W-1:0] n_right;
	logic                       clear;
	int                         idx;

	always_comb begin
		row     = '0;
		col     = '0;
		n_right = '0;
		clear   = 1'b1;
		idx     = 0;
		result.cells    = '0;
		result.cells[0] = 1'b1;
		// first move sits in the top bit
		for (int m = gmpe_pkg::NMOVES - 1; m >= 0; m--) begin
			if (moves[m]) begin
				col     = col + 1'b1;
				n_right = n_right + 1'b1;
			end else begin
				row = row + 1'b1;
			end
			idx = int'(row) * gmpe_pkg::SIDE + int'(col);
			if (idx < gmpe_pkg::CELLS) begin
				if (grid_mask[gmpe_pkg::IDX_W'(idx)])
					clear = 1'b0;
				result.cells[gmpe_pkg::IDX_W'(idx)] = 1'b1;
			end else begin
				clear = 1'b0;
			end
		end
		// only words with exactly side-1 right moves end at the goal
		result.hit = clear && (n_right == gmpe_pkg::POS_W'(gmpe_pkg::SIDE - 1));
	end

endmodule

[design/grid_monotone_path_enumerator_core.sv]
// ----------------------------------------------------------------------------
// grid_monotone_path_enumerator_core - rat-in-a-maze path enumerator
// a found path is held until the next one is found, so the first result of a
//   grid leaves when its second path is found, or from the flush state when
//   it is the only result; a new grid is taken only back in the idle state
// an output stall holds the scan only while a newly found path or the final
//   result waits on a full output register
// the candidate counter steps the shared evaluator through one move word per
//   cycle while the scan is not stalled, in ascending order, which is
//   depth-first down-first
// reset: arst_n clears the sequencer, the held-path valid and the output valid; payload unreset
// ----------------------------------------------------------------------------
module grid_monotone_path_enumerator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gmpe_pkg::MASK_W-1:0]   blocked_mask,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gmpe_pkg::MASK_W-1:0]   path_cells,
	output logic                          path_valid,
	output logic                          last_path
);

	// sequencer state
	gmpe_pkg::seq_state_t  state_q, state_d;
	gmpe_pkg::cell_mask_t  grid_q;      // latched blocked mask of the grid
	gmpe_pkg::move_word_t  cand_q;      // candidate move word under test
	gmpe_pkg::eval_result_t eval;

	// one found path is held back until we know whether another follows,
	// so that the final one can carry last_path
	logic                  pend_valid_q;
	gmpe_pkg::cell_mask_t  pend_cells_q;

	// output register, parts the scan from the consumer
	logic                  out_valid_q;
	gmpe_pkg::cell_mask_t  out_cells_q;
	logic                  out_pvalid_q;
	logic                  out_last_q;

	// control decoded by the sequencer
	logic out_free;
	logic grid_load;
	logic cand_step;
	logic emit_mid;
	logic emit_end;

	gmpe_path_eval u_eval (
		.grid_mask (grid_q),
		.moves     (cand_q),
		.result    (eval)
	);

	assign out_free = !out_valid_q || out_ready;

	// next state and control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		grid_load = 1'b0;
		cand_step = 1'b0;
		emit_mid  = 1'b0;
		emit_end  = 1'b0;
		case (state_q)
			gmpe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					grid_load = 1'b1;
					state_d   = gmpe_pkg::ST_SCAN;
				end
			end
			gmpe_pkg::ST_SCAN: begin
				// a new hit pushes the held path out, which needs a free output slot
				if (!(eval.hit && pend_valid_q && !out_free)) begin
					cand_step = 1'b1;
					emit_mid  = eval.hit && pend_valid_q;
					if (cand_q == '1)
						state_d = gmpe_pkg::ST_FLUSH;
				end
			end
			gmpe_pkg::ST_FLUSH: begin
				// final result: the held path, or the no-path answer
				if (out_free) begin
					emit_end = 1'b1;
					state_d  = gmpe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gmpe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmpe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// grid latch and candidate counter
	always_ff @(posedge clk) begin
		if (grid_load) begin
			grid_q <= blocked_mask[gmpe_pkg::CELLS-1:0];
			cand_q <= '0;
		end else if (cand_step) begin
			cand_q <= cand_q + 1'b1;
		end
	end

	// held path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (grid_load) begin
			pend_valid_q <= 1'b0;
		end else if (cand_step && eval.hit) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_step && eval.hit)
			pend_cells_q <= eval.cells;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_mid || emit_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_mid || emit_end) begin
			out_cells_q  <= pend_valid_q ? pend_cells_q : '0;
			out_pvalid_q <= pend_valid_q;
			out_last_q   <= emit_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign path_cells = gmpe_pkg::MASK_W'(out_cells_q);
	assign path_valid = out_pvalid_q;
	assign last_path  = out_last_q;

	// a grid is taken only from idle, so the next cycle is never ready
	a_busy_after_accept : assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	// the no-path answer is always the final result
	a_nopath_last : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !path_valid) |-> last_path)
		else $error("no-path result without last_path");

	// a found path covers both corners and exactly 2*side-1 cells
	a_path_shape : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && path_valid) |->
		(path_cells[0] && path_cells[gmpe_pkg::CELLS-1] &&
		 $countones(path_cells) == 2 * gmpe_pkg::SIDE - 1))
		else $error("malformed path mask");

	// no result is produced while the block waits for a grid
	a_idle_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gmpe_pkg::ST_IDLE) |-> !(emit_mid || emit_end))
		else $error("result emitted while idle");

endmodule

[sim/grid_monotone_path_enumerator_core_test.sv]
// ----------------------------------------------------------------------------
// grid_monotone_path_enumerator_core_test - path enumerator testbench
// feeds blocked-cell masks through a directed table and then a random run,
// predicts every down/right path from top-left to bottom-right in depth-first
// down-first order, and checks each output transaction against the oldest
// prediction while both sides idle and stall at random
// ----------------------------------------------------------------------------
module grid_monotone_path_enumerator_core_test;

	localparam int RANDOM_GRIDS = 196;
	localparam int MAX_PATHS    = 20;
	localparam int SETTLE       = (1 << gmpe_pkg::NMOVES) + 16;
	localparam int REPORT_LIMIT = 10;

	// one output transaction as the block presents it
	typedef struct packed {
		logic [gmpe_pkg::MASK_W-1:0] cells;
		logic                        valid;
		logic                        is_last;
	} path_result_t;

	// one row of the directed table; typed rows carry their single answer
	typedef struct packed {
		logic [gmpe_pkg::MASK_W-1:0] mask;
		logic                        typed;
		path_result_t                want;
	} grid_vector_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_STREAM,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	localparam path_result_t NO_PATH   = '{cells: '0, valid: 1'b0, is_last: 1'b1};
	localparam path_result_t DONT_CARE = '{cells: '0, valid: 1'b0, is_last: 1'b0};

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [gmpe_pkg::MASK_W-1:0] blocked_mask;
	logic                        out_valid;
	logic                        out_ready;
	logic [gmpe_pkg::MASK_W-1:0] path_cells;
	logic                        path_valid;
	logic                        last_path;

	// expected path transactions, oldest first
	path_result_t      pending_paths[$];
	int                mismatch_count;

	// side information for the grid currently offered on the input
	logic              offer_typed;
	path_result_t      offer_want;

	// directed table: extremes, blocked start and goal, single corridors,
	// no-path cases and each cell blocked on its own
	grid_vector_t directed_grids [24] = '{
		'{16'h0000, 1'b0, DONT_CARE},                        // open grid, all 20 paths
		'{16'hFFFF, 1'b1, NO_PATH},                          // everything blocked
		'{16'h8000, 1'b1, NO_PATH},                          // goal blocked
		'{16'hFFFE, 1'b1, NO_PATH},                          // only the start is free
		'{16'h7770, 1'b1, '{16'h888F, 1'b1, 1'b1}},          // top row then right column
		'{16'h0EEE, 1'b1, '{16'hF111, 1'b1, 1'b1}},          // left column then bottom row
		'{16'h7771, 1'b1, '{16'h888F, 1'b1, 1'b1}},          // blocked start is ignored
		'{16'h0001, 1'b0, DONT_CARE},                        // blocked start, open grid
		'{16'h0012, 1'b1, NO_PATH},                          // both first steps blocked
		'{16'h0002, 1'b0, DONT_CARE},
		'{16'h0004, 1'b0, DONT_CARE},
		'{16'h0008, 1'b0, DONT_CARE},
		'{16'h0010, 1'b0, DONT_CARE},
		'{16'h0020, 1'b0, DONT_CARE},
		'{16'h0040, 1'b0, DONT_CARE},
		'{16'h0080, 1'b0, DONT_CARE},
		'{16'h0100, 1'b0, DONT_CARE},
		'{16'h0200, 1'b0, DONT_CARE},
		'{16'h0400, 1'b0, DONT_CARE},
		'{16'h0800, 1'b0, DONT_CARE},
		'{16'h1000, 1'b0, DONT_CARE},
		'{16'h2000, 1'b0, DONT_CARE},
		'{16'h4000, 1'b0, DONT_CARE},
		'{16'h6996, 1'b0, DONT_CARE}                         // scattered blockage
	};

	grid_monotone_path_enumerator_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.blocked_mask (blocked_mask),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.path_cells   (path_cells),
		.path_valid   (path_valid),
		.last_path    (last_path)
	);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// walk every move word in ascending order: the top bit is the first move,
	// 0 steps down and 1 steps right, so ascending order is depth-first with
	// down tried first; only words with SIDE-1 right steps end on the goal
	function automatic void enumerate_paths(input logic [gmpe_pkg::MASK_W-1:0] mask);
		gmpe_pkg::cell_mask_t grid;
		gmpe_pkg::cell_mask_t covered;
		gmpe_pkg::move_word_t word;
		path_result_t         hits [MAX_PATHS];
		int                   found;
		int                   row;
		int                   col;
		int                   idx;
		int                   m;
		bit                   clear;
		grid  = mask[gmpe_pkg::CELLS-1:0];  // bits past the grid are ignored
		found = 0;
		for (int w = 0; w < (1 << gmpe_pkg::NMOVES); w++) begin
			word = w[gmpe_pkg::NMOVES-1:0];
			if ($countones(word) != gmpe_pkg::SIDE - 1)
				continue;
			row     = 0;
			col     = 0;
			clear   = 1'b1;
			covered = '0;
			covered[0] = 1'b1;  // the start is always on the path
			for (m = gmpe_pkg::NMOVES - 1; m >= 0; m--) begin
				if (word[m])
					col++;
				else
					row++;
				idx = row * gmpe_pkg::SIDE + col;
				if (grid[gmpe_pkg::IDX_W'(idx)]) begin
					clear = 1'b0;
					break;
				end
				covered[gmpe_pkg::IDX_W'(idx)] = 1'b1;
			end
			if (clear && found < MAX_PATHS) begin
				hits[found] = '{cells: gmpe_pkg::MASK_W'(covered), valid: 1'b1,
					is_last: 1'b0};
				found++;
			end
		end
		if (found == 0) begin
			pending_paths.push_back(NO_PATH);
		end else begin
			hits[found-1].is_last = 1'b1;
			for (int i = 0; i < found; i++)
				pending_paths.push_back(hits[i]);
		end
	endfunction

	function automatic void note_mismatch(input string what, input path_result_t want,
			input path_result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t %s: expected cells=%h valid=%b last=%b, got cells=%h valid=%b last=%b",
				$time, what, want.cells, want.valid, want.is_last,
				got.cells, got.valid, got.is_last);
	endfunction

	// input transactions queue their predictions, output transactions are
	// checked field by field against the oldest one
	always @(posedge clk) begin
		path_result_t got;
		path_result_t want;
		if (arst_n && in_valid && in_ready) begin
			if (offer_typed)
				pending_paths.push_back(offer_want);
			else
				enumerate_paths(blocked_mask);
		end
		if (arst_n && out_valid && out_ready) begin
			got = '{cells: path_cells, valid: path_valid, is_last: last_path};
			if (pending_paths.size() == 0) begin
				note_mismatch("unexpected result", DONT_CARE, got);
			end else begin
				want = pending_paths.pop_front();
				if (got.cells !== want.cells || got.valid !== want.valid ||
						got.is_last !== want.is_last)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	// offer one grid from the current falling edge and hold it until taken;
	// returns at the falling edge after the transaction
	task automatic send_grid(input logic [gmpe_pkg::MASK_W-1:0] mask, input logic typed,
			input path_result_t want);
		in_valid     <= 1'b1;
		blocked_mask <= mask;
		offer_typed  <= typed;
		offer_want   <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// sender bursts: back-to-back offers, then a random gap
	int burst_left;

	task automatic pace_sender();
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(negedge clk);
			burst_left = $urandom_range(12, 1);
		end
		burst_left--;
	endtask

	// stop offering until every queued path has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_paths.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		burst_left = 0;
	endtask

	// mostly sparse grids so that paths survive, some dense noise, and a few
	// grids with the goal blocked or the start bit set
	function automatic logic [gmpe_pkg::MASK_W-1:0] random_grid();
		logic [gmpe_pkg::MASK_W-1:0] a;
		logic [gmpe_pkg::MASK_W-1:0] b;
		logic [gmpe_pkg::MASK_W-1:0] c;
		a = gmpe_pkg::MASK_W'($urandom());
		b = gmpe_pkg::MASK_W'($urandom());
		c = gmpe_pkg::MASK_W'($urandom());
		case ($urandom_range(9, 0))
			0, 1:       return a;
			2, 3, 4, 5: return a & b;
			6, 7:       return a & b & c;
			8:          return (a & b & c) | 16'h0001;
			default:    return (a & b) | 16'h8000;
		endcase
	endfunction

	// stimulus
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		blocked_mask   = '0;
		offer_typed    = 1'b0;
		offer_want     = DONT_CARE;
		mismatch_count = 0;
		burst_left     = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_grids[i]) begin
			pace_sender();
			send_grid(directed_grids[i].mask, directed_grids[i].typed, directed_grids[i].want);
		end

		// hold off until the directed part has fully drained
		drain_results();

		for (int n = 0; n < RANDOM_GRIDS; n++) begin
			if (n == RANDOM_GRIDS / 2)
				drain_results();
			pace_sender();
			send_grid(random_grid(), 1'b0, DONT_CARE);
		end
		in_valid <= 1'b0;

		while (pending_paths.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatch_count == 0)
			$display("[grid_monotone_path_enumerator_core] OK");
		else
			$display("[grid_monotone_path_enumerator_core] ERROR");
		$finish;
	end

	// receiver: stretches of full rate, random stalls and a periodic pattern
	initial begin
		rx_mode_t mode;
		int       span;
		int       period;
		int       duty;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode   = rx_mode_t'($urandom_range(2, 0));
			span   = $urandom_range(300, 40);
			period = $urandom_range(9, 2);
			duty   = $urandom_range(period - 1, 1);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					RX_STREAM: out_ready <= 1'b1;
					RX_RANDOM: out_ready <= ($urandom_range(3, 0) != 0);
					default:   out_ready <= ((k % period) < duty);
				endcase
			end
		end
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("[grid_monotone_path_enumerator_core] ERROR");
		$finish;
	end

endmodule
